// ----- src/crfp_pkg.sv -----
package crfp_pkg;

    localparam int unsigned ID_W = 31;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NAME    = 2'd0;
    localparam kind_t KIND_HASH    = 2'd1;
    localparam kind_t KIND_SUMMARY = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [3:0] DEC_BASE = 4'd10;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef struct packed {
        logic            has;
        kind_t           kind;
        logic [7:0]      field_byte;
        logic            ok;
        logic [ID_W-1:0] user_id;
    } result_t;

endpackage

// ----- src/crfp_core.sv -----
module crfp_core
    import crfp_pkg::*;
#(
    parameter int unsigned NAME_LIMIT = 64,
    parameter int unsigned HASH_LIMIT = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       line_end,
    output result_t    res
);

    localparam int unsigned LIM_MAX = (NAME_LIMIT > HASH_LIMIT) ? NAME_LIMIT : HASH_LIMIT;
    localparam int unsigned CNT_W   = $clog2(LIM_MAX);
    localparam int unsigned CMP_W   = CNT_W + 1;
    localparam int unsigned WIDE_W  = ID_W + 4;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_HASH,
        PH_ID,
        PH_REST,
        PH_FAIL
    } phase_t;

    phase_t            phase_reg,     phase_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [ID_W-1:0]   id_reg,        id_next;
    logic              digit_reg,     digit_next;
    logic              nonempty_reg,  nonempty_next;

    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  count_inc;
    logic [WIDE_W-1:0] id_wide;
    logic [3:0]        digit_val;
    logic              is_digit;
    logic              summary_ok;

    assign limit = (phase_reg == PH_NAME) ? CMP_W'(NAME_LIMIT) : CMP_W'(HASH_LIMIT);
    assign count_inc = {1'b0, count_reg} + CMP_W'(1);

    assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign digit_val = 4'(data_byte - CHAR_ZERO);

    // id * 10 + digit as shifts and adds
    assign id_wide = ({4'b0, id_reg} << 3) + ({4'b0, id_reg} << 1)
                   + {{(WIDE_W-4){1'b0}}, digit_val};

    assign summary_ok = nonempty_reg && digit_reg
                      && (phase_reg == PH_ID || phase_reg == PH_REST);

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        id_next       = id_reg;
        digit_next    = digit_reg;
        nonempty_next = nonempty_reg;
        res           = '0;

        if (line_end)
        begin
            res.has       = 1'b1;
            res.kind      = KIND_SUMMARY;
            res.ok        = summary_ok;
            res.user_id   = summary_ok ? id_reg : '0;
            phase_next    = PH_NAME;
            count_next    = '0;
            id_next       = '0;
            digit_next    = 1'b0;
            nonempty_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_NAME, PH_HASH:
                begin
                    if (data_byte == CHAR_NUL)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        nonempty_next = 1'b1;
                        if (data_byte == CHAR_COLON)
                        begin
                            phase_next = (phase_reg == PH_NAME) ? PH_HASH : PH_ID;
                            count_next = '0;
                        end
                        else if (count_inc < limit)
                        begin
                            count_next     = count_inc[CNT_W-1:0];
                            res.has        = 1'b1;
                            res.kind       = (phase_reg == PH_NAME) ? KIND_NAME : KIND_HASH;
                            res.field_byte = data_byte;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                end
                PH_ID:
                begin
                    if (data_byte == CHAR_NUL)
                    begin
                        phase_next = PH_REST;
                    end
                    else
                    begin
                        nonempty_next = 1'b1;
                        if (is_digit)
                        begin
                            digit_next = 1'b1;
                            id_next    = (id_wide > {4'b0, ID_MAX}) ? ID_MAX
                                                                    : id_wide[ID_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_REST;
                        end
                    end
                end
                PH_REST, PH_FAIL:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NAME;
            count_reg    <= '0;
            id_reg       <= '0;
            digit_reg    <= 1'b0;
            nonempty_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            id_reg       <= id_next;
            digit_reg    <= digit_next;
            nonempty_reg <= nonempty_next;
        end
    end

endmodule

// ----- src/colon_record_field_parser.sv -----
// Parser for one text record per line of the form name:hash:id[:rest], fed one
// byte word per cycle while in_stall is low, with line_end marking the end of a
// line. Name and hash characters come out as kind 0 and kind 1 words as they
// arrive; line_end gives one kind 2 summary with record_ok and the decimal id
// (saturated at 2^31-1). It takes one word every cycle unless stalled: an
// input register feeds a single pass of per-byte logic into a result register,
// so a word's result is written there as the word leaves the input register;
// in_stall rises only while the result register is full and out_stall holds it.
module colon_record_field_parser
    import crfp_pkg::*;
#(
    parameter int unsigned NAME_LIMIT = 64,
    parameter int unsigned HASH_LIMIT = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            line_end,
    output logic            out_valid,
    input  logic            out_stall,
    output kind_t           result_kind,
    output logic [7:0]      field_byte,
    output logic            record_ok,
    output logic [ID_W-1:0] user_id
);

    logic            s1_valid_reg;
    logic [7:0]      s1_data_reg;
    logic            s1_eol_reg;

    logic            out_valid_reg;
    kind_t           kind_reg;
    logic [7:0]      byte_reg;
    logic            ok_reg;
    logic [ID_W-1:0] id_reg;

    logic            advance;
    logic            step;
    result_t         res;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    crfp_core #(
        .NAME_LIMIT (NAME_LIMIT),
        .HASH_LIMIT (HASH_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_data_reg),
        .line_end  (s1_eol_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= step && res.has;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= data_byte;
            s1_eol_reg  <= line_end;
        end
        if (step && res.has)
        begin
            kind_reg <= res.kind;
            byte_reg <= res.field_byte;
            ok_reg   <= res.ok;
            id_reg   <= res.user_id;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign field_byte  = byte_reg;
    assign record_ok   = ok_reg;
    assign user_id     = id_reg;

endmodule
